FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: hdl/pcicfg_pkg.sv
package pcicfg_pkg;

  // Configuration space geometry: four byte banks, one byte lane each
  localparam int unsigned CONFIG_BYTES = 256;
  localparam int unsigned OFF_W        = $clog2(CONFIG_BYTES);
  localparam int unsigned BANKS        = 4;
  localparam int unsigned BANK_W       = $clog2(BANKS);
  localparam int unsigned ROWS         = CONFIG_BYTES / BANKS;
  localparam int unsigned ROW_W        = OFF_W - BANK_W;
  localparam int unsigned CNT_W        = BANK_W + 1;
  localparam int unsigned BAR_BYTES    = 8;

  // Port operations
  typedef enum logic [1:0] {
    OP_ADDR_WR = 2'd0,
    OP_ADDR_RD = 2'd1,
    OP_DATA_WR = 2'd2,
    OP_DATA_RD = 2'd3
  } op_e;

  // Access widths
  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_WORD  = 2'd1,
    SZ_DWORD = 2'd2,
    SZ_BAD   = 2'd3
  } size_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEVICES = 2'd0,
    CFG_VENDOR  = 2'd1,
    CFG_DEVICE  = 2'd2,
    CFG_LFB     = 2'd3
  } cfg_reg_e;

  // Address decode
  localparam logic [31:0] TARGET_MASK  = 32'h80ff_0000;
  localparam logic [31:0] TARGET_MATCH = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

  // Register reset values
  localparam logic [15:0] VENDOR_RST = 16'h5333;
  localparam logic [15:0] DEVICE_RST = 16'h8811;
  localparam logic [31:0] LFB_RST    = 32'hc000_0000;

  // Base address handling
  localparam logic [31:0]      BAR_MASK  = 32'hffff_fff0;
  localparam logic [31:0]      BAR1_STEP = 32'h0100_0000;
  localparam logic [7:0]       BAR0_KEEP = 8'h0f;
  localparam logic [OFF_W-1:0] BAR_FIRST = 8'h10;
  localparam logic [OFF_W-1:0] BAR_LAST  = 8'h17;

  // Header type byte
  localparam logic [OFF_W-1:0] HDR_TYPE_OFF  = 8'h0e;
  localparam logic [7:0]       HDR_TYPE_MASK = 8'h7f;
  localparam logic [OFF_W-1:0] IDENT_LAST    = 8'h03;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // word accepted: latch it, issue bank reads or writes
    logic finish;  // load the result register
  } ctl_cmd_t;

  // Power-on contents outside the identifiers and base address bytes
  function automatic logic [7:0] init_byte(logic [OFF_W-1:0] off);
    logic [7:0] b;
    case (off)
      8'h04:   b = 8'h23;
      8'h06:   b = 8'h80;
      8'h07:   b = 8'h02;
      8'h0b:   b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_bar(logic [OFF_W-1:0] off);
    return (off >= BAR_FIRST) && (off <= BAR_LAST);
  endfunction

  // Writable bytes; the header type byte itself is never writable
  function automatic logic is_writable(logic [OFF_W-1:0] off);
    logic hdr0;
    logic ro;
    hdr0 = (init_byte(HDR_TYPE_OFF) & HDR_TYPE_MASK) == 8'h00;
    ro = (off inside {[8'h00:8'h03], [8'h06:8'h0b], 8'h0e, [8'h18:8'h27], [8'h30:8'h33]})
         || (hdr0 && (off inside {[8'h28:8'h2f]}));
    return !ro;
  endfunction

  function automatic logic [CNT_W-1:0] byte_count(size_e sz);
    logic [CNT_W-1:0] n;
    case (sz)
      SZ_BYTE:  n = CNT_W'(1);
      SZ_WORD:  n = CNT_W'(2);
      SZ_DWORD: n = CNT_W'(4);
      default:  n = '0;
    endcase
    return n;
  endfunction

  // Both base address registers from the frame buffer base, {bar1, bar0}
  function automatic logic [63:0] lfb_bars(logic [31:0] lfb);
    logic [31:0] bar0;
    logic [31:0] bar1;
    bar0 = lfb & BAR_MASK;
    bar1 = (lfb + BAR1_STEP) & BAR_MASK;
    return {bar1, bar0};
  endfunction

endpackage

FILE: hdl/pcicfg_ram.sv
module pcicfg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pcicfg_ctrl.sv
module pcicfg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcicfg_pkg::ctl_cmd_t cmd_o
);
  import pcicfg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   start, finish;

  assign start  = in_valid_i && (state_q == S_IDLE);
  assign finish = (state_q == S_RUN) && (!out_valid_q || !out_stall_i);

  // Sequencer: accept, then form the result once the output register is free
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_RUN;
      end
      S_RUN: begin
        if (finish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output word held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.start  = start;
  assign cmd_o.finish = finish;

endmodule

FILE: hdl/pcicfg_datapath.sv
module pcicfg_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcicfg_pkg::ctl_cmd_t cmd_i,
  input  logic [1:0]           operation_i,
  input  logic [1:0]           byte_lane_i,
  input  logic [1:0]           access_size_i,
  input  logic [31:0]          write_value_i,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output logic [31:0]          read_data_o
);
  import pcicfg_pkg::*;

  // Configuration and address registers
  logic        devices_q;
  logic [15:0] vendor_q, device_q;
  logic [31:0] addr_q;
  logic [63:0] bar_q, bar_d;
  logic [CONFIG_BYTES-1:0] valid_q, valid_d;

  // Word latched at accept
  op_e              op_q;
  logic [OFF_W-1:0] reg_q;
  logic [CNT_W-1:0] count_q;
  logic             ok_q;
  logic [31:0]      out_q;

  // Accept-time decode
  op_e              op_a;
  logic [OFF_W-1:0] reg_a;
  logic [CNT_W-1:0] count_a;
  logic             ok_a;
  logic             wr_go, rd_go;

  logic [BANK_W-1:0] idx_a [BANKS];
  logic [OFF_W-1:0]  off_a [BANKS];
  logic [BANKS-1:0]  acc_a;
  logic [BANKS-1:0]  ram_we;
  logic [7:0]        wbyte [BANKS];
  logic [7:0]        rdata [BANKS];
  logic [BANK_W-1:0] idx_r [BANKS];
  logic [OFF_W-1:0]  off_r [BANKS];
  logic [7:0]        raw   [BANKS];
  logic [7:0]        view  [BANKS];
  logic [31:0]       ident;
  logic [31:0]       data_rd;
  logic [31:0]       result;

  assign op_a    = op_e'(operation_i);
  assign reg_a   = {addr_q[OFF_W-1:BANK_W], byte_lane_i};
  assign count_a = byte_count(size_e'(access_size_i));
  assign ok_a    = ((addr_q & TARGET_MASK) == TARGET_MATCH)
                   && (addr_q[15:11] < 5'(devices_q))
                   && (addr_q[10:8] == 3'd0);
  assign wr_go   = cmd_i.start && (op_a == OP_DATA_WR) && ok_a;
  assign rd_go   = cmd_i.start && (op_a == OP_DATA_RD);
  assign ident   = {device_q, vendor_q};

  // Byte banks: each access touches a bank at most once
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    assign idx_a[b]  = BANK_W'(b) - reg_a[BANK_W-1:0];
    assign off_a[b]  = reg_a + OFF_W'(idx_a[b]);
    assign acc_a[b]  = CNT_W'(idx_a[b]) < count_a;
    assign wbyte[b]  = write_value_i[{idx_a[b], 3'b000} +: 8];
    assign ram_we[b] = wr_go && acc_a[b] && is_writable(off_a[b]) && !is_bar(off_a[b]);
    assign idx_r[b]  = BANK_W'(b) - reg_q[BANK_W-1:0];
    assign off_r[b]  = reg_q + OFF_W'(idx_r[b]);

    pcicfg_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (off_a[b][OFF_W-1:BANK_W]),
      .wdata_i (wbyte[b]),
      .re_i    (rd_go),
      .raddr_i (off_a[b][OFF_W-1:BANK_W]),
      .rdata_o (rdata[b])
    );
  end

  // Base address bytes: reload on lfb_base, masking rules on data writes
  always_comb begin
    bar_d = bar_q;
    if (cfg_valid_i && (cfg_index_i == CFG_LFB)) begin
      bar_d = lfb_bars(cfg_data_i);
    end else begin
      for (int k = 0; k < BAR_BYTES; k++) begin
        if (wr_go && acc_a[BANK_W'(k)]
            && (off_a[BANK_W'(k)] == BAR_FIRST + OFF_W'(k))) begin
          case (k)
            0, 4:    bar_d[8*k +: 8] = bar_q[7:0] & BAR0_KEEP;
            1, 2, 5: bar_d[8*k +: 8] = 8'h00;
            default: bar_d[8*k +: 8] = wbyte[BANK_W'(k)];
          endcase
        end
      end
    end
  end

  // Written-entry marks; unmarked entries read their power-on value
  always_comb begin
    valid_d = valid_q;
    for (int b = 0; b < BANKS; b++) begin
      if (ram_we[b]) valid_d[off_a[b]] = 1'b1;
    end
  end

  // Per-bank read view
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      raw[b] = valid_q[off_r[b]] ? rdata[b] : init_byte(off_r[b]);
      if (off_r[b] <= IDENT_LAST) begin
        view[b] = ident[{off_r[b][1:0], 3'b000} +: 8];
      end else if (is_bar(off_r[b])) begin
        view[b] = bar_q[{off_r[b][2:0], 3'b000} +: 8];
      end else if (off_r[b] == HDR_TYPE_OFF) begin
        view[b] = raw[b] & HDR_TYPE_MASK;
      end else begin
        view[b] = raw[b];
      end
    end
  end

  // Assemble the read word, lowest offset in the low byte
  always_comb begin
    logic [BANK_W-1:0] sel;
    sel     = '0;
    data_rd = '0;
    for (int i = 0; i < BANKS; i++) begin
      sel = reg_q[BANK_W-1:0] + BANK_W'(i);
      data_rd[8*i +: 8] = (CNT_W'(i) < count_q) ? view[sel] : 8'h00;
    end
  end

  always_comb begin
    case (op_q)
      OP_ADDR_RD: result = addr_q;
      OP_DATA_RD: result = (ok_q && (count_q != '0)) ? data_rd : ALL_ONES;
      default:    result = '0;
    endcase
  end

  // Control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      devices_q <= 1'b1;
      vendor_q  <= VENDOR_RST;
      device_q  <= DEVICE_RST;
      addr_q    <= '0;
      bar_q     <= lfb_bars(LFB_RST);
      valid_q   <= '0;
    end else begin
      bar_q   <= bar_d;
      valid_q <= valid_d;
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_DEVICES: devices_q <= cfg_data_i[0];
          CFG_VENDOR:  vendor_q  <= cfg_data_i[15:0];
          CFG_DEVICE:  device_q  <= cfg_data_i[15:0];
          default:     ;
        endcase
      end
      if (cmd_i.start && (op_a == OP_ADDR_WR)) begin
        addr_q <= write_value_i;
      end
    end
  end

  // Word latch and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= op_a;
      reg_q   <= reg_a;
      count_q <= count_a;
      ok_q    <= ok_a;
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  assign read_data_o = out_q;

endmodule

FILE: hdl/pci_config_space_access.sv
// PCI configuration mechanism 1 bridge with one display device at bus 0, slot 0,
// function 0. Each input word is one port access (address write/read, data
// write/read of 1, 2 or 4 bytes at lane 0-3) and gives exactly one output word.
// An access is accepted in S_IDLE: that cycle decodes the target and issues
// reads or writes to four byte-wide 64-entry RAM banks (one per byte lane); in
// S_RUN the result is built from the registered bank data once the output
// register is free. A new word is accepted only back in S_IDLE; the result
// register lets the next word in while the last result still waits. Per-byte written
// flags cleared by reset give the power-on contents at once, so no clearing
// pass follows reset. Configuration writes are always ready.
module pci_config_space_access (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  byte_lane_i,
  input  logic [1:0]  access_size_i,
  input  logic [31:0] write_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import pcicfg_pkg::*;

  ctl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  pcicfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pcicfg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .byte_lane_i   (byte_lane_i),
    .access_size_i (access_size_i),
    .write_value_i (write_value_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .read_data_o   (read_data_o)
  );

endmodule

FILE: hdl/pcicfg_checker.sv
`include "assert_macros.svh"

module pcicfg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  operation_i,
  input logic [1:0]  byte_lane_i,
  input logic [1:0]  access_size_i,
  input logic [31:0] write_value_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  // One access at a time: busy right after a word is taken
  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "input not stalled after accept")

  // With a free output register the result shows once the sequencer has passed S_RUN and loaded the output register
  `ASSERT_RST(a_result_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o && !out_valid_o) |=> ##1 out_valid_o, "result late")

  // Stalled output word holds
  `ASSERT_RST(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_data_o)), "stalled output changed")

  // No output word while in reset
  `ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind pci_config_space_access pcicfg_checker u_checker (.*);
